/* hdl/olstore_pkg.sv */
// Shared types, constants and helpers for the ordered list store.
// Used by olstore_mem, olstore_ctrl and ordered_list_store_core.
package olstore_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    // command codes
    localparam logic [2:0] CMD_APPEND     = 3'd0;
    localparam logic [2:0] CMD_PREPEND    = 3'd1;
    localparam logic [2:0] CMD_POP_BACK   = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;
    localparam logic [2:0] CMD_REMOVE_AT  = 3'd5;
    localparam logic [2:0] CMD_REMOVE_VAL = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] item_value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [8:0]               entry_count;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // circular slot of logical index idx: (front + idx) mod CAPACITY
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] front,
                                                  input logic [ADDR_W-1:0] idx);
        logic [ADDR_W:0] sum;
        logic [ADDR_W:0] cap;
        cap = (ADDR_W+1)'(CAPACITY);
        sum = {1'b0, front} + {1'b0, idx};
        if (sum >= cap) begin
            sum = sum - cap;
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

/* hdl/olstore_mem.sv */
// Entry memory: one write port, one read port with registered read data.
// Depends on olstore_pkg for depth, widths and the request struct.
module olstore_mem (
    input  logic                                i_clk,
    input  olstore_pkg::t_mem_req               i_req,
    output logic [olstore_pkg::DATA_W-1:0]      o_rd_data
);

    logic [olstore_pkg::DATA_W-1:0] r_mem [olstore_pkg::CAPACITY];
    logic [olstore_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/olstore_ctrl.sv */
// Command sequencer: front pointer, occupancy, and the one-entry-per-cycle
// scan unit that searches and shifts entries through the memory port.
// Depends on olstore_pkg.
module olstore_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  olstore_pkg::t_in_item           i_req,
    input  logic                            i_res_ready,
    input  logic [olstore_pkg::DATA_W-1:0]  i_rd_data,
    output logic                            o_idle,
    output logic                            o_res_valid,
    output olstore_pkg::t_out_item          o_res,
    output olstore_pkg::t_mem_req           o_mem
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state                                r_state, n_state;
    logic [olstore_pkg::ADDR_W-1:0]        r_front, n_front;
    logic [olstore_pkg::CNT_W-1:0]         r_occ, n_occ;
    logic [olstore_pkg::CNT_W-1:0]         r_idx, n_idx;
    logic                                  r_rd_live, n_rd_live;
    logic [olstore_pkg::DATA_W-1:0]        r_val, n_val;
    logic [2:0]                            r_status, n_status;
    logic [olstore_pkg::DATA_W-1:0]        r_rdval, n_rdval;

    logic                                  full;
    logic                                  empty;
    logic                                  pos_range;
    logic [olstore_pkg::CNT_W-1:0]         idx_inc;
    logic [olstore_pkg::CNT_W-1:0]         shift_i;
    logic [olstore_pkg::CNT_W-1:0]         shift_inc;
    logic [olstore_pkg::ADDR_W-1:0]        front_next;
    olstore_pkg::t_mem_req                 mem;

    assign full      = r_occ >= olstore_pkg::CNT_W'(olstore_pkg::CAPACITY);
    assign empty     = r_occ == '0;
    assign pos_range = olstore_pkg::CMP_W'(i_req.position) >= olstore_pkg::CMP_W'(r_occ);
    assign idx_inc   = r_idx + 1'b1;
    assign shift_i   = r_rd_live ? idx_inc : r_idx;
    assign shift_inc = shift_i + 1'b1;
    assign front_next = olstore_pkg::slot_of(r_front, olstore_pkg::ADDR_W'(1));

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_rd_live = r_rd_live;
        n_val     = r_val;
        n_status  = r_status;
        n_rdval   = r_rdval;
        mem       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val    = i_req.item_value;
                    n_status = olstore_pkg::ST_OK;
                    n_rdval  = '0;
                    n_state  = S_DONE;
                    case (i_req.cmd)
                        olstore_pkg::CMD_APPEND: begin
                            if (full) begin
                                n_status = olstore_pkg::ST_FULL;
                            end else begin
                                mem.we    = 1'b1;
                                mem.waddr = olstore_pkg::slot_of(r_front,
                                                r_occ[olstore_pkg::ADDR_W-1:0]);
                                mem.wdata = i_req.item_value;
                                n_occ     = r_occ + 1'b1;
                            end
                        end
                        olstore_pkg::CMD_PREPEND: begin
                            if (full) begin
                                n_status = olstore_pkg::ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ?
                                    olstore_pkg::ADDR_W'(olstore_pkg::CAPACITY - 1) :
                                    r_front - 1'b1;
                                mem.we    = 1'b1;
                                mem.waddr = n_front;
                                mem.wdata = i_req.item_value;
                                n_occ     = r_occ + 1'b1;
                            end
                        end
                        olstore_pkg::CMD_POP_BACK: begin
                            if (empty) begin
                                n_status = olstore_pkg::ST_EMPTY;
                            end else begin
                                n_occ = r_occ - 1'b1;
                            end
                        end
                        olstore_pkg::CMD_POP_FRONT: begin
                            if (empty) begin
                                n_status = olstore_pkg::ST_EMPTY;
                            end else begin
                                n_front = front_next;
                                n_occ   = r_occ - 1'b1;
                            end
                        end
                        olstore_pkg::CMD_READ: begin
                            if (empty) begin
                                n_status = olstore_pkg::ST_EMPTY;
                            end else if (pos_range) begin
                                n_status = olstore_pkg::ST_RANGE;
                            end else begin
                                mem.re    = 1'b1;
                                mem.raddr = olstore_pkg::slot_of(r_front,
                                                olstore_pkg::ADDR_W'(i_req.position));
                                n_state   = S_READ;
                            end
                        end
                        olstore_pkg::CMD_REMOVE_AT: begin
                            if (empty) begin
                                n_status = olstore_pkg::ST_EMPTY;
                            end else if (pos_range) begin
                                n_status = olstore_pkg::ST_RANGE;
                            end else if (i_req.position == '0) begin
                                n_front = front_next;
                                n_occ   = r_occ - 1'b1;
                            end else begin
                                n_idx     = olstore_pkg::CNT_W'(i_req.position);
                                n_rd_live = 1'b0;
                                n_state   = S_SHIFT;
                            end
                        end
                        olstore_pkg::CMD_REMOVE_VAL: begin
                            if (empty) begin
                                n_status = olstore_pkg::ST_EMPTY;
                            end else begin
                                mem.re    = 1'b1;
                                mem.raddr = r_front;
                                n_idx     = '0;
                                n_state   = S_SEARCH;
                            end
                        end
                        default: begin
                            n_status = olstore_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rdval = i_rd_data;
                n_state = S_DONE;
            end
            S_SEARCH: begin
                // read data belongs to logical index r_idx
                if (i_rd_data == r_val) begin
                    if (r_idx == '0) begin
                        n_front = front_next;
                        n_occ   = r_occ - 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_rd_live = 1'b0;
                        n_state   = S_SHIFT;
                    end
                end else if (idx_inc >= r_occ) begin
                    n_status = olstore_pkg::ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    mem.re    = 1'b1;
                    mem.raddr = olstore_pkg::slot_of(r_front,
                                    idx_inc[olstore_pkg::ADDR_W-1:0]);
                    n_idx     = idx_inc;
                end
            end
            S_SHIFT: begin
                // write entry i with the data of entry i+1 read last cycle
                if (r_rd_live) begin
                    mem.we    = 1'b1;
                    mem.waddr = olstore_pkg::slot_of(r_front,
                                    r_idx[olstore_pkg::ADDR_W-1:0]);
                    mem.wdata = i_rd_data;
                end
                if (shift_inc < r_occ) begin
                    mem.re    = 1'b1;
                    mem.raddr = olstore_pkg::slot_of(r_front,
                                    shift_inc[olstore_pkg::ADDR_W-1:0]);
                    n_rd_live = 1'b1;
                    n_idx     = shift_i;
                end else begin
                    n_rd_live = 1'b0;
                    n_occ     = r_occ - 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_occ     <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_occ     <= n_occ;
            r_rd_live <= n_rd_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_status <= n_status;
        r_rdval  <= n_rdval;
    end

    assign o_idle              = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_DONE);
    assign o_res.status        = r_status;
    assign o_res.read_value    = r_rdval;
    assign o_res.entry_count   = 9'(r_occ);
    assign o_mem               = mem;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= olstore_pkg::CNT_W'(olstore_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_state != S_IDLE))
        else $error("accepted command did not leave idle");

    a_rdval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status != olstore_pkg::ST_OK) |-> (r_rdval == '0))
        else $error("read value not zero on failed command");

    a_shift_ports_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && mem.we && mem.re) |-> (mem.waddr != mem.raddr))
        else $error("shift writes and reads the same slot");
`endif

endmodule

/* hdl/ordered_list_store_core.sv */
// Ordered list store: circular entry memory under a command sequencer.
// Append, prepend, pops, remove at 0, unused and early-rejected commands go straight
// to the result state; read passes through the memory-read state; other removes use
// the scan unit, which moves one entry per cycle through the memory port.
// One command at a time: input ready is low until the result enters the output register.
// Reset (synchronous, active low) empties the store; entries are not cleared.
module ordered_list_store_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  olstore_pkg::t_in_item   i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output olstore_pkg::t_out_item  o_out_data
);

    logic                               idle;
    logic                               start;
    logic                               res_valid;
    logic                               res_ready;
    olstore_pkg::t_out_item             res;
    olstore_pkg::t_mem_req              mem_req;
    logic [olstore_pkg::DATA_W-1:0]     rd_data;
    logic                               r_out_valid;
    olstore_pkg::t_out_item             r_out;

    assign o_in_ready = idle;
    assign start      = i_in_valid & idle;
    assign res_ready  = !r_out_valid || i_out_ready;

    olstore_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_in_data),
        .i_res_ready (res_ready),
        .i_rd_data   (rd_data),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem       (mem_req)
    );

    olstore_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // output register: hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
